FILE: rtl/core/spjq_pkg.sv
package spjq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int SIZE_W      = 16;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic [PRIO_W-1:0] prio;
  } job_t;

  // What one cell shows its neighbors: occupancy, whether it stays put on an
  // insert of the current job, and its contents.
  typedef struct packed {
    logic valid;
    logic keep;
    job_t job;
  } link_t;

  // Broadcast to every cell in a cycle.
  typedef struct packed {
    logic insert;
    logic remove;
    job_t new_job;
  } cell_ctl_t;

endpackage

FILE: rtl/core/spjq_cell.sv
module spjq_cell
  import spjq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  link_t     left,
  input  link_t     right,
  output link_t     self
);

  logic valid;
  logic valid_next;
  job_t job;
  job_t job_next;
  logic keep;

  // A held job stays ahead of a new job of equal or higher priority number.
  assign keep = valid && (ctl.new_job.prio >= job.prio);

  assign self.valid = valid;
  assign self.keep  = keep;
  assign self.job   = job;

  always_comb begin
    valid_next = valid;
    job_next   = job;
    if (ctl.insert) begin
      valid_next = valid | left.valid;
      if (!keep) begin
        job_next = left.keep ? ctl.new_job : left.job;
      end
    end else if (ctl.remove) begin
      valid_next = right.valid;
      job_next   = right.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
  end

endmodule

FILE: rtl/core/sorted_priority_job_queue_top.sv
// A command is taken at the edge where start is high and busy is low,
// and its result is shown with done high in the next cycle, for one cycle.
// Throughput: one command per cycle; busy stays low because every cell compares
// and shifts in parallel, so the row of cells sets this rate.
// Reset (synchronous, active high) empties the queue and clears done; the
// receiver cannot stall, so each result must be taken in its done cycle.
module sorted_priority_job_queue_top
  import spjq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [ID_W-1:0]     job_id,
  input  logic [SIZE_W-1:0]   job_size,
  input  logic [PRIO_W-1:0]   job_priority,
  output logic                done,
  output logic                out_valid,
  output logic [ID_W-1:0]     out_id,
  output logic [SIZE_W-1:0]   out_size,
  output logic [PRIO_W-1:0]   out_priority,
  output logic [STATUS_W-1:0] status,
  output logic [OCC_W-1:0]    occupancy
);

  link_t                  links [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  cell_ctl_t              ctl;
  logic [CNT_W-1:0]       job_count;
  logic [CNT_W-1:0]       job_count_next;
  logic                   empty;
  logic                   full;
  logic                   is_insert;
  logic                   is_remove;
  status_t                status_next;

  assign busy = 1'b0;

  assign empty = !links[0].valid;
  assign full  = links[QUEUE_DEPTH-1].valid;

  assign is_insert = start && (opcode == OP_INSERT);
  assign is_remove = start && (opcode == OP_REMOVE);

  assign ctl.insert       = is_insert && !full;
  assign ctl.remove       = is_remove && !empty;
  assign ctl.new_job.id   = job_id;
  assign ctl.new_job.size = job_size;
  assign ctl.new_job.prio = job_priority;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    link_t left_in;
    link_t right_in;

    if (i == 0) begin : g_head
      // The head has nothing ahead of it: a job that lands here takes the
      // new job.
      assign left_in = '{valid: 1'b1, keep: 1'b1, job: '0};
    end else begin : g_body
      assign left_in = links[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_in = '{valid: 1'b0, keep: 1'b0, job: '0};
    end else begin : g_inner
      assign right_in = links[i+1];
    end

    spjq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .self  (links[i])
    );

    assign cell_valid[i] = links[i].valid;
  end

  always_comb begin
    job_count_next = job_count;
    status_next    = ST_OK;
    if (ctl.insert) begin
      job_count_next = job_count + CNT_W'(1);
    end else if (ctl.remove) begin
      job_count_next = job_count - CNT_W'(1);
    end
    if (is_insert && full) begin
      status_next = ST_FULL;
    end else if (is_remove && empty) begin
      status_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count <= '0;
      done      <= 1'b0;
    end else begin
      job_count <= job_count_next;
      done      <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      out_valid    <= ctl.remove;
      out_id       <= ctl.remove ? links[0].job.id   : '0;
      out_size     <= ctl.remove ? links[0].job.size : '0;
      out_priority <= ctl.remove ? links[0].job.prio : '0;
      status       <= status_next;
      occupancy    <= OCC_W'(job_count_next);
    end
  end

  // Occupied cells always form an unbroken run from the head.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + QUEUE_DEPTH'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(job_count))
    else $error("job count disagrees with occupied cells");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("accepted command produced no result");

  a_report_on_good_remove: assert property (@(posedge clk) disable iff (rst)
    (is_remove && !empty) |=> (out_valid && status == ST_OK))
    else $error("remove on a non-empty queue did not report its job");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (is_insert && full) |=> $stable(job_count))
    else $error("dropped insert changed the job count");

endmodule
